@@ rtl/locd_pkg.sv @@
// Shared types and constants for the lock order cycle detector.
package locd_pkg;
    localparam int NUM_LOCKS  = 32;
    localparam int HOLD_DEPTH = 16;
    localparam int ID_W  = 5;
    localparam int HC_W  = $clog2(HOLD_DEPTH + 1);
    localparam int HI_W  = $clog2(HOLD_DEPTH);
    localparam int ST_W  = 3;
    localparam int VO_W  = $clog2(NUM_LOCKS + 1);
    localparam int SP_W  = $clog2(NUM_LOCKS + 1);
    localparam int NI_W  = $clog2(NUM_LOCKS);

    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_OK             = 3'd0;
    localparam t_status ST_DEADLOCK       = 3'd1;
    localparam t_status ST_MULTI_UNLOCK   = 3'd2;
    localparam t_status ST_INVALID_UNLOCK = 3'd3;
    localparam t_status ST_OVERFLOW       = 3'd4;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // queued command from front to back
    typedef struct packed {
        logic            acquire;
        logic            search;
        logic [ID_W-1:0] lock_id;
        t_status         status;
    } t_cmd;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] edge_from;
        logic [ID_W-1:0] edge_to;
    } t_result;
endpackage

@@ rtl/locd_front.sv @@
// Front end: holds the lock stack and order matrix, classifies each event.
module locd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_op,
    input  logic [locd_pkg::ID_W-1:0]   i_lock_id,
    output logic                        o_cmd_valid,
    output locd_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_ready,
    input  logic                        i_busy,
    input  logic                        i_done,
    input  logic                        i_dead,
    input  logic [locd_pkg::NI_W-1:0]   i_row_addr,
    output logic [locd_pkg::NUM_LOCKS-1:0] o_row
);
    import locd_pkg::*;

    logic [NUM_LOCKS-1:0] r_matrix [NUM_LOCKS];
    logic [ID_W-1:0]      r_stack [HOLD_DEPTH];
    logic [HC_W-1:0]      r_count;
    logic                 r_wait;   // search outstanding; stack update pending
    logic [ID_W-1:0]      r_pend_id;

    logic [ID_W-1:0] top;
    logic            has_top, new_edge, fire;
    t_status         st;

    assign top     = r_stack[HI_W'(r_count - HC_W'(1))];
    assign has_top = (r_count != '0);
    assign new_edge = has_top && top != i_lock_id &&
                      32'(top) < NUM_LOCKS && 32'(i_lock_id) < NUM_LOCKS &&
                      !r_matrix[NI_W'(top)][NI_W'(i_lock_id)];
    assign o_full  = r_wait || !i_cmd_ready || i_busy;
    assign fire    = i_push && !o_full;
    assign o_row   = r_matrix[i_row_addr];

    always_comb begin
        st = ST_OK;
        if (i_op == OP_ACQUIRE) begin
            if (32'(r_count) >= HOLD_DEPTH) st = ST_OVERFLOW;
        end else if (!has_top) begin
            st = ST_MULTI_UNLOCK;
        end else if (top != i_lock_id) begin
            st = ST_INVALID_UNLOCK;
        end
    end

    assign o_cmd_valid     = fire;
    assign o_cmd.acquire   = (i_op == OP_ACQUIRE);
    assign o_cmd.search    = (i_op == OP_ACQUIRE) && new_edge;
    assign o_cmd.lock_id   = i_lock_id;
    assign o_cmd.status    = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wait  <= 1'b0;
            for (int k = 0; k < NUM_LOCKS; k++) r_matrix[k] <= '0;
        end else begin
            if (fire) begin
                if (o_cmd.search) begin
                    r_matrix[NI_W'(top)][NI_W'(i_lock_id)] <= 1'b1;
                    r_wait    <= 1'b1;
                    r_pend_id <= i_lock_id;
                end else if (i_op == OP_ACQUIRE) begin
                    if (st == ST_OK) begin
                        r_stack[HI_W'(r_count)] <= i_lock_id;
                        r_count <= r_count + HC_W'(1);
                    end
                end else if (st == ST_OK) begin
                    r_count <= r_count - HC_W'(1);
                end
            end
            if (r_wait && i_done) begin
                r_wait <= 1'b0;
                if (!i_dead && 32'(r_count) < HOLD_DEPTH) begin
                    r_stack[HI_W'(r_count)] <= r_pend_id;
                    r_count <= r_count + HC_W'(1);
                end
            end
        end
    end
endmodule

@@ rtl/locd_back.sv @@
// Back end: command queue, DFS sequencer and result queue.
module locd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  locd_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_ready,
    output logic                           o_busy,
    output logic                           o_done,
    output logic                           o_dead,
    output logic [locd_pkg::NI_W-1:0]      o_row_addr,
    input  logic [locd_pkg::NUM_LOCKS-1:0] i_row,
    output logic                           o_empty,
    input  logic                           i_pop,
    output locd_pkg::t_result              o_res
);
    import locd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_STEP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_cmd_v;
    t_result r_res;
    logic   r_res_v;
    logic [NUM_LOCKS-1:0] r_vis, r_done;
    logic [VO_W-1:0] r_ord [NUM_LOCKS];
    logic [ID_W-1:0] r_sstk [NUM_LOCKS];
    logic [SP_W-1:0] r_cur [NUM_LOCKS];
    logic [SP_W-1:0] r_sp;
    logic [SP_W-1:0] r_root;
    logic [VO_W-1:0] r_cnt;
    logic            r_dead;
    logic [ID_W-1:0] r_ef, r_et;

    logic [ID_W-1:0] here;
    logic [SP_W-1:0] cur;
    logic [NUM_LOCKS-1:0] masked;
    logic            found;
    logic [NI_W-1:0] nb;
    logic            res_load;

    assign here = r_sstk[NI_W'(r_sp - SP_W'(1))];
    assign cur  = r_cur[NI_W'(r_sp - SP_W'(1))];
    assign o_row_addr = NI_W'(here);
    always_comb begin
        masked = '0;
        for (int k = 0; k < NUM_LOCKS; k++)
            masked[k] = i_row[k] && (32'(k) >= 32'(cur));
        found = 1'b0;
        nb = '0;
        for (int k = NUM_LOCKS - 1; k >= 0; k--)
            if (masked[k]) begin
                found = 1'b1;
                nb = NI_W'(k);
            end
    end

    // result register loads this cycle
    assign res_load = ((r_state == S_IDLE) && r_cmd_v && !r_cmd.search &&
                       (!r_res_v || i_pop)) ||
                      ((r_state == S_OUT) && !r_res_v);

    assign o_cmd_ready = !r_cmd_v;
    assign o_busy  = (r_state != S_IDLE) || r_cmd_v;
    assign o_done  = (r_state == S_OUT) && !r_res_v;
    assign o_dead  = r_dead;
    assign o_empty = !r_res_v;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd_v <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            if (i_pop && r_res_v && !res_load) r_res_v <= 1'b0;
            if (i_cmd_valid && !r_cmd_v) begin
                r_cmd   <= i_cmd;
                r_cmd_v <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_cmd_v) begin
                        if (r_cmd.search) begin
                            r_vis  <= '0;
                            r_done <= '0;
                            r_cnt  <= '0;
                            r_root <= '0;
                            r_dead <= 1'b0;
                            r_state <= S_ROOT;
                        end else if (!r_res_v || i_pop) begin
                            r_res.status    <= r_cmd.status;
                            r_res.edge_from <= '0;
                            r_res.edge_to   <= '0;
                            r_res_v <= 1'b1;
                            r_cmd_v <= 1'b0;
                        end
                    end
                end
                S_ROOT: begin
                    if (32'(r_root) >= NUM_LOCKS) begin
                        r_state <= S_OUT;
                    end else if (r_vis[NI_W'(r_root)]) begin
                        r_root <= r_root + SP_W'(1);
                    end else begin
                        r_vis[NI_W'(r_root)] <= 1'b1;
                        r_ord[NI_W'(r_root)] <= r_cnt;
                        r_cnt <= r_cnt + VO_W'(1);
                        r_sstk[0] <= ID_W'(r_root);
                        r_cur[0]  <= '0;
                        r_sp <= SP_W'(1);
                        r_root <= r_root + SP_W'(1);
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_sp == '0) begin
                        r_state <= S_ROOT;
                    end else if (!found) begin
                        r_done[NI_W'(here)] <= 1'b1;
                        r_sp <= r_sp - SP_W'(1);
                    end else begin
                        r_cur[NI_W'(r_sp - SP_W'(1))] <= SP_W'(nb) + SP_W'(1);
                        if (!r_vis[nb]) begin
                            if (32'(r_sp) < NUM_LOCKS) begin
                                r_vis[nb] <= 1'b1;
                                r_ord[nb] <= r_cnt;
                                r_cnt <= r_cnt + VO_W'(1);
                                r_sstk[NI_W'(r_sp)] <= ID_W'(nb);
                                r_cur[NI_W'(r_sp)]  <= '0;
                                r_sp <= r_sp + SP_W'(1);
                            end
                        end else if (r_ord[NI_W'(here)] >= r_ord[nb] && !r_done[nb]) begin
                            r_dead <= 1'b1;
                            r_ef <= here;
                            r_et <= ID_W'(nb);
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_res_v) begin
                        r_res.status    <= r_dead ? ST_DEADLOCK : r_cmd.status;
                        r_res.edge_from <= r_dead ? r_ef : '0;
                        r_res.edge_to   <= r_dead ? r_et : '0;
                        r_res_v <= 1'b1;
                        r_cmd_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/lock_order_cycle_detector_core.sv @@
// Lock order cycle detector: takes one event at a time.
// Event without a new ordering edge: held in the command register, then moved to the result register once it is free.
// New edge: graph search by the single DFS sequencer, which tries each root, walks
// each edge and finishes each node in turn.
// Synchronous active-low reset clears the order matrix, lock stack and queues.
module lock_order_cycle_detector_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_op,
    input  logic [4:0] i_lock_id,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_status,
    output logic [4:0] o_edge_from,
    output logic [4:0] o_edge_to
);
    import locd_pkg::*;

    logic cmd_valid, cmd_ready, busy, done, dead;
    t_cmd cmd;
    t_result res;
    logic [NI_W-1:0] row_addr;
    logic [NUM_LOCKS-1:0] row;

    locd_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_lock_id,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_ready(cmd_ready),
        .i_busy(busy), .i_done(done), .i_dead(dead),
        .i_row_addr(row_addr), .o_row(row)
    );

    locd_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_ready(cmd_ready), .o_busy(busy), .o_done(done), .o_dead(dead),
        .o_row_addr(row_addr), .i_row(row), .o_empty(empty), .i_pop(pop),
        .o_res(res)
    );

    assign o_status    = res.status;
    assign o_edge_from = res.edge_from;
    assign o_edge_to   = res.edge_to;
endmodule

@@ tb/lock_order_cycle_detector_core_tb.sv @@
// Self-checking testbench for the lock order cycle detector core.
module lock_order_cycle_detector_core_tb;
    import locd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_op = OP_ACQUIRE;
    logic [4:0] i_lock_id = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] o_status;
    logic [4:0] o_edge_from;
    logic [4:0] o_edge_to;

    lock_order_cycle_detector_core dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow state of the detector
    logic [NUM_LOCKS-1:0] order_rows [NUM_LOCKS];
    logic [ID_W-1:0]      held_ids [HOLD_DEPTH];
    int                   held_depth;

    t_result pending_results[$];
    int      err_count;
    int      idle_cycles;
    int      results_seen;
    int      status_hits [5];
    bit      no_gaps;

    typedef struct {
        logic            op;
        logic [ID_W-1:0] id;
        bit              typed;
        t_status         status;
        logic [ID_W-1:0] efrom;
        logic [ID_W-1:0] eto;
    } t_row;

    // DFS over the whole ordering graph; first back edge closes a cycle
    function automatic bit search_cycle(output logic [ID_W-1:0] efrom,
                                        output logic [ID_W-1:0] eto);
        int  disc [NUM_LOCKS];
        bit  seen [NUM_LOCKS];
        bit  finished [NUM_LOCKS];
        int  dstack [NUM_LOCKS];
        int  cursor [NUM_LOCKS];
        int  sp, here, n, count;
        count = 0;
        efrom = '0;
        eto = '0;
        for (int k = 0; k < NUM_LOCKS; k++) begin
            seen[k] = 0;
            finished[k] = 0;
            disc[k] = 0;
        end
        for (int root = 0; root < NUM_LOCKS; root++) begin
            if (seen[root]) continue;
            seen[root] = 1;
            disc[root] = count++;
            dstack[0] = root;
            cursor[0] = 0;
            sp = 1;
            while (sp > 0) begin
                here = dstack[sp-1];
                n = cursor[sp-1];
                while (n < NUM_LOCKS && !order_rows[here][n]) n++;
                if (n >= NUM_LOCKS) begin
                    finished[here] = 1;
                    sp--;
                    continue;
                end
                cursor[sp-1] = n + 1;
                if (!seen[n]) begin
                    if (sp < NUM_LOCKS) begin
                        seen[n] = 1;
                        disc[n] = count++;
                        dstack[sp] = n;
                        cursor[sp] = 0;
                        sp++;
                    end
                    continue;
                end
                if (disc[here] < disc[n]) continue;
                if (!finished[n]) begin
                    efrom = here[ID_W-1:0];
                    eto = n[ID_W-1:0];
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic t_result apply_event(logic op, logic [ID_W-1:0] id);
        t_result r;
        bit dead;
        logic [ID_W-1:0] prev;
        r = '{status: ST_OK, edge_from: '0, edge_to: '0};
        dead = 0;
        if (op == OP_ACQUIRE) begin
            if (held_depth > 0) begin
                prev = held_ids[held_depth-1];
                if (prev != id && !order_rows[prev][id]) begin
                    order_rows[prev][id] = 1'b1;
                    dead = search_cycle(r.edge_from, r.edge_to);
                end
            end
            if (dead) r.status = ST_DEADLOCK;
            else if (held_depth >= HOLD_DEPTH) r.status = ST_OVERFLOW;
            else held_ids[held_depth++] = id;
        end else begin
            if (held_depth == 0) r.status = ST_MULTI_UNLOCK;
            else if (held_ids[held_depth-1] != id) r.status = ST_INVALID_UNLOCK;
            else held_depth--;
        end
        if (r.status != ST_DEADLOCK) begin
            r.edge_from = '0;
            r.edge_to = '0;
        end
        return r;
    endfunction

    task automatic offer_event(logic op, logic [ID_W-1:0] id, bit typed = 0,
                               t_result typed_res = '0);
        t_result r;
        @(negedge i_clk);
        push <= 1'b1;
        i_op <= op;
        i_lock_id <= id;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        r = apply_event(op, id);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic sender_gap();
        int r, n;
        r = $urandom_range(99);
        if (no_gaps || r < 60) n = 0;
        else if (r < 92) n = $urandom_range(3, 1);
        else n = $urandom_range(40, 10);
        if (n > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // receiver: random pop, one long hold-off to back up the block
    initial begin
        int r;
        bit held_off;
        held_off = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= 30) begin
                held_off = 1;
                pop <= 1'b0;
                repeat (600) @(negedge i_clk);
            end
            r = $urandom_range(99);
            if (no_gaps || r < 65) pop <= 1'b1;
            else if (r < 95) pop <= 1'b0;
            else begin
                pop <= 1'b0;
                repeat ($urandom_range(30, 8)) @(negedge i_clk);
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d", o_status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_edge_from != want.edge_from) begin
                    $error("edge_from: expected %0d, got %0d", want.edge_from,
                           o_edge_from);
                    err_count++;
                end
                if (o_edge_to != want.edge_to) begin
                    $error("edge_to: expected %0d, got %0d", want.edge_to, o_edge_to);
                    err_count++;
                end
                if (want.status <= ST_OVERFLOW) status_hits[want.status]++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout waiting for a handshake");
            $display("lock_order_cycle_detector_core_tb: errors");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_result tr;
        int      r;
        logic [ID_W-1:0] id;

        err_count = 0;
        idle_cycles = 0;
        results_seen = 0;
        held_depth = 0;
        no_gaps = 0;
        foreach (status_hits[k]) status_hits[k] = 0;
        foreach (order_rows[k]) order_rows[k] = '0;
        foreach (held_ids[k]) held_ids[k] = '0;

        rows.push_back('{OP_RELEASE, 5'd5,  1, ST_MULTI_UNLOCK, 0, 0});
        rows.push_back('{OP_ACQUIRE, 5'd0,  1, ST_OK, 0, 0});
        rows.push_back('{OP_ACQUIRE, 5'd31, 1, ST_OK, 0, 0});
        rows.push_back('{OP_RELEASE, 5'd0,  1, ST_INVALID_UNLOCK, 0, 0});
        rows.push_back('{OP_RELEASE, 5'd31, 1, ST_OK, 0, 0});
        rows.push_back('{OP_RELEASE, 5'd0,  1, ST_OK, 0, 0});
        rows.push_back('{OP_ACQUIRE, 5'd31, 1, ST_OK, 0, 0});
        // reverse order closes the cycle 0 -> 31 -> 0
        rows.push_back('{OP_ACQUIRE, 5'd0,  1, ST_DEADLOCK, 5'd31, 5'd0});
        rows.push_back('{OP_RELEASE, 5'd31, 1, ST_OK, 0, 0});
        // same lock taken again adds no edge; fill the stack, then overflow
        for (int k = 0; k < HOLD_DEPTH; k++)
            rows.push_back('{OP_ACQUIRE, 5'd21, 0, ST_OK, 0, 0});
        rows.push_back('{OP_ACQUIRE, 5'd21, 1, ST_OVERFLOW, 0, 0});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            tr = '{status: rows[k].status, edge_from: rows[k].efrom,
                   edge_to: rows[k].eto};
            offer_event(rows[k].op, rows[k].id, rows[k].typed, tr);
            sender_gap();
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 150 == 0) no_gaps = ($urandom_range(2) == 0);
            r = $urandom_range(99);
            // a small pool of ids makes reversed orderings likely
            id = ($urandom_range(9) < 7) ? 5'($urandom_range(7)) : 5'($urandom);
            if (k % 100 >= 80) begin
                // acquire burst to reach overflow
                offer_event(OP_ACQUIRE, id);
            end else if (r < 6) begin
                offer_event(OP_RELEASE, 5'($urandom));
            end else if (r < 50 && held_depth > 0) begin
                offer_event(OP_RELEASE, held_ids[held_depth-1]);
            end else begin
                offer_event(OP_ACQUIRE, id);
            end
            sender_gap();
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) err_count++;

        $display("covered %0d results: ok %0d, deadlock %0d, multi unlock %0d,",
                 results_seen, status_hits[0], status_hits[1], status_hits[2]);
        $display("invalid unlock %0d, overflow %0d", status_hits[3], status_hits[4]);
        if (err_count == 0) begin
            $display("lock_order_cycle_detector_core_tb: clean");
        end else begin
            $display("lock_order_cycle_detector_core_tb: errors");
        end
        $finish;
    end
endmodule
